[rtl/tmp_pkg.sv]
// ----------------------------------------------------------------------------
// tmp_pkg: shared types and constants of the trapezoid motion profile block
// Holds the item type that passes from the front to the back, the request
// and response types of the shared divider and root units, and the widths.
// ----------------------------------------------------------------------------
package tmp_pkg;

  // Number of fraction bits of the fixed-point values.
  localparam int unsigned FRAC_BITS = 16;

  // Field widths.
  localparam int unsigned VAL_W = 32;
  localparam int unsigned SQR_W = 2 * VAL_W;
  localparam int unsigned TOL_W = 16;

  // Divider widths: the dividend holds the signed-free meet numerator,
  // the divisor holds four times the acceleration.
  localparam int unsigned DIV_W  = SQR_W + 4;
  localparam int unsigned DVS_W  = VAL_W + 2;
  localparam int unsigned DCNT_W = $clog2(DIV_W);
  localparam int unsigned SCNT_W = $clog2(VAL_W);

  // One motion block as it waits in the queue.
  typedef struct packed {
    logic [VAL_W-1:0] entry_speed;
    logic [VAL_W-1:0] nominal_speed;
    logic [VAL_W-1:0] exit_speed;
    logic [VAL_W-1:0] accel_rate;
    logic [VAL_W-1:0] block_length;
    logic             accel_zero;
  } item_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  // Square root request and response.
  typedef struct packed {
    logic             start;
    logic [SQR_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] root;
  } sqrt_rsp_t;

endpackage

[rtl/trapezoid_motion_profile.sv]
// ----------------------------------------------------------------------------
// trapezoid_motion_profile: trapezoidal speed profile of one motion block
// Gives the ramp end points, the reached cruise speed, the ramp times and a
// cruise-only flag of a block, in unsigned Q16.16.
//
//   channel | direction | handshake            | payload
//   in      | request   | in_valid/in_ready    | three speeds, rate, length
//   out     | result    | out_valid/out_ready  | six profile fields
//   cfg     | write     | cfg_valid/cfg_ready  | cruise-only tolerance
//
// A block with nonzero acceleration passes the shared divider five times when
// the ramps overlap and four times otherwise, and the root unit twice; the
// intake, the products, the range check and the output load are steps of
// their own. A block with zero acceleration goes from the intake straight to
// the output load. The back end takes the next request in the cycle after its
// output load and works on one block at a time. Requests queue two deep ahead
// of the back end. One finished result waits in the output register without
// stopping work on the next request; the back end stalls in its last step only
// while that register is still full.
// Reset clears the queue, the sequencer and the output valid, and sets the
// tolerance to one.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] entry_speed_i,
  input  logic [31:0] nominal_speed_i,
  input  logic [31:0] exit_speed_i,
  input  logic [31:0] accel_rate_i,
  input  logic [31:0] block_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] accel_end_o,
  output logic [31:0] decel_start_o,
  output logic [31:0] cruise_speed_o,
  output logic [31:0] accel_duration_o,
  output logic [31:0] decel_duration_o,
  output logic        cruise_only_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import tmp_pkg::*;

  item_t             item;
  logic              item_valid;
  logic              pop;
  logic [TOL_W-1:0]  tol_q;

  // Tolerance register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(1);
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  tmp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .entry_speed_i   (entry_speed_i),
    .nominal_speed_i (nominal_speed_i),
    .exit_speed_i    (exit_speed_i),
    .accel_rate_i    (accel_rate_i),
    .block_length_i  (block_length_i),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .pop_i           (pop)
  );

  tmp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_valid),
    .item_i           (item),
    .pop_o            (pop),
    .tolerance_i      (tol_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .accel_end_o      (accel_end_o),
    .decel_start_o    (decel_start_o),
    .cruise_speed_o   (cruise_speed_o),
    .accel_duration_o (accel_duration_o),
    .decel_duration_o (decel_duration_o),
    .cruise_only_o    (cruise_only_o)
  );

endmodule

[rtl/tmp_front.sv]
// ----------------------------------------------------------------------------
// tmp_front: request intake and queue
// Accepts motion block requests, flags a zero acceleration and holds up to
// two requests for the back end.
// ----------------------------------------------------------------------------
module tmp_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [31:0]            entry_speed_i,
  input  logic [31:0]            nominal_speed_i,
  input  logic [31:0]            exit_speed_i,
  input  logic [31:0]            accel_rate_i,
  input  logic [31:0]            block_length_i,
  output logic                   item_valid_o,
  output tmp_pkg::item_t         item_o,
  input  logic                   pop_i
);
  import tmp_pkg::*;

  item_t       fifo_q [2];
  item_t       item_in;
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  logic        pop;

  // Classify the incoming request.
  always_comb begin
    item_in.entry_speed   = entry_speed_i;
    item_in.nominal_speed = nominal_speed_i;
    item_in.exit_speed    = exit_speed_i;
    item_in.accel_rate    = accel_rate_i;
    item_in.block_length  = block_length_i;
    item_in.accel_zero    = (accel_rate_i == '0);
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && item_valid_o;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

[rtl/tmp_div.sv]
// ----------------------------------------------------------------------------
// tmp_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle over the full dividend.
// ----------------------------------------------------------------------------
module tmp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tmp_pkg::div_req_t  req_i,
  output tmp_pkg::div_rsp_t  rsp_o
);
  import tmp_pkg::*;

  localparam logic [DCNT_W-1:0] LastCnt = DCNT_W'(DIV_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [DIV_W-1:0]  sh_q, sh_d;
  logic [DVS_W:0]    trial;
  logic              ge;

  // One restoring step.
  always_comb begin
    trial = {rem_q, sh_q[DIV_W-1]};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
    sh_d  = {sh_q[DIV_W-2:0], ge};
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LastCnt);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      sh_q  <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;

endmodule

[rtl/tmp_sqrt.sv]
// ----------------------------------------------------------------------------
// tmp_sqrt: iterative integer square root
// Digit-by-digit root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module tmp_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmp_pkg::sqrt_req_t  req_i,
  output tmp_pkg::sqrt_rsp_t  rsp_o
);
  import tmp_pkg::*;

  localparam logic [SCNT_W-1:0] LastCnt = SCNT_W'(VAL_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [SCNT_W-1:0] cnt_q;
  logic [VAL_W+1:0]  rem_q, rem_d;
  logic [VAL_W-1:0]  root_q, root_d;
  logic [SQR_W-1:0]  sh_q;
  logic [VAL_W+3:0]  part;
  logic [VAL_W+3:0]  trial;
  logic              ge;

  // One root digit.
  always_comb begin
    part   = {rem_q, sh_q[SQR_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = (part >= trial);
    rem_d  = ge ? (VAL_W+2)'(part - trial) : part[VAL_W+1:0];
    root_d = {root_q[VAL_W-2:0], ge};
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LastCnt);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      root_q <= '0;
      sh_q   <= req_i.radicand;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      sh_q   <= {sh_q[SQR_W-3:0], 2'b00};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

[rtl/tmp_back.sv]
// ----------------------------------------------------------------------------
// tmp_back: profile sequencer
// Works out one queued block with a shared multiplier, divider and root
// unit, and holds the result in an output register.
// ----------------------------------------------------------------------------
module tmp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  tmp_pkg::item_t      item_i,
  output logic                pop_o,
  input  logic [15:0]         tolerance_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         accel_end_o,
  output logic [31:0]         decel_start_o,
  output logic [31:0]         cruise_speed_o,
  output logic [31:0]         accel_duration_o,
  output logic [31:0]         decel_duration_o,
  output logic                cruise_only_o
);
  import tmp_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE      = 17'h00001,
    ST_SQ_E      = 17'h00002,
    ST_SQ_C      = 17'h00004,
    ST_SQ_X      = 17'h00008,
    ST_MUL_AL    = 17'h00010,
    ST_DIV_AD    = 17'h00020,
    ST_DIV_DD    = 17'h00040,
    ST_CHECK     = 17'h00080,
    ST_DIV_MEET  = 17'h00100,
    ST_MUL_SU    = 17'h00200,
    ST_SQRT_SU   = 17'h00400,
    ST_DIV_TA    = 17'h00800,
    ST_MUL_CR    = 17'h01000,
    ST_MUL_PD    = 17'h02000,
    ST_SQRT_SD   = 17'h04000,
    ST_DIV_TD    = 17'h08000,
    ST_OUT       = 17'h10000
  } state_e;

  state_e            state_q, state_d;
  logic              run_q;
  item_t             it_q;
  logic [SQR_W-1:0]  e2_q, c2_q, x2_q, al_q, p_q, cr2_q;
  logic [SQR_W-1:0]  ad_q, dd_q;
  logic [VAL_W-1:0]  acc_q, dec_q, cr_q, su_q, sd_q, ta_q, td_q;
  logic              meet_q;

  logic [VAL_W-1:0]  mul_a, mul_b;
  logic [SQR_W-1:0]  prod;
  logic              div_state, sqrt_state;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  sqrt_req_t         sqrt_req;
  sqrt_rsp_t         sqrt_rsp;
  logic [DIV_W-1:0]  meet_num;
  logic [SQR_W:0]    ramp_sum;
  logic [SQR_W+1:0]  up_sum;
  logic [SQR_W:0]    two_p;
  logic [VAL_W-1:0]  quot_sat;
  logic [VAL_W-1:0]  meet_pt;
  logic              load_out;
  logic [VAL_W-1:0]  span;

  tmp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tmp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  // Shared multiplier operands.
  always_comb begin
    mul_a = it_q.accel_rate;
    mul_b = it_q.block_length;
    unique case (state_q)
      ST_SQ_E: begin
        mul_a = it_q.entry_speed;
        mul_b = it_q.entry_speed;
      end
      ST_SQ_C: begin
        mul_a = it_q.nominal_speed;
        mul_b = it_q.nominal_speed;
      end
      ST_SQ_X: begin
        mul_a = it_q.exit_speed;
        mul_b = it_q.exit_speed;
      end
      ST_MUL_SU: mul_b = acc_q;
      ST_MUL_CR: begin
        mul_a = cr_q;
        mul_b = cr_q;
      end
      ST_MUL_PD: mul_b = it_q.block_length - dec_q;
      default: begin
        mul_a = it_q.accel_rate;
        mul_b = it_q.block_length;
      end
    endcase
  end

  assign prod = SQR_W'(mul_a) * SQR_W'(mul_b);

  // Intermediate sums.
  always_comb begin
    meet_num = DIV_W'({al_q, 1'b0}) + DIV_W'(x2_q) - DIV_W'(e2_q);
    ramp_sum = {1'b0, ad_q} + {1'b0, dd_q};
    up_sum   = (SQR_W+2)'(e2_q) + (SQR_W+2)'({p_q, 1'b0});
    two_p    = {p_q, 1'b0};
    quot_sat = (div_rsp.quot[DIV_W-1:VAL_W] != '0) ? '1 : div_rsp.quot[VAL_W-1:0];
    meet_pt  = (div_rsp.quot > DIV_W'(it_q.block_length)) ? it_q.block_length
                                                          : div_rsp.quot[VAL_W-1:0];
  end

  // Divider requests; a negative numerator divides as zero.
  always_comb begin
    div_state        = state_q[5] | state_q[6] | state_q[8] | state_q[11] | state_q[15];
    div_req.start    = div_state && !run_q;
    div_req.divisor  = {1'b0, it_q.accel_rate, 1'b0};
    div_req.dividend = '0;
    unique case (state_q)
      ST_DIV_AD: begin
        if (c2_q > e2_q) begin
          div_req.dividend = DIV_W'(c2_q - e2_q);
        end
      end
      ST_DIV_DD: begin
        if (c2_q > x2_q) begin
          div_req.dividend = DIV_W'(c2_q - x2_q);
        end
      end
      ST_DIV_MEET: begin
        div_req.divisor = {it_q.accel_rate, 2'b00};
        if (!meet_num[DIV_W-1]) begin
          div_req.dividend = meet_num;
        end
      end
      ST_DIV_TA: begin
        div_req.divisor = DVS_W'(it_q.accel_rate);
        if (su_q > it_q.entry_speed) begin
          div_req.dividend = DIV_W'(su_q - it_q.entry_speed) << FRAC_BITS;
        end
      end
      ST_DIV_TD: begin
        div_req.divisor = DVS_W'(it_q.accel_rate);
        if (cr_q > sd_q) begin
          div_req.dividend = DIV_W'(cr_q - sd_q) << FRAC_BITS;
        end
      end
      default: div_req.dividend = '0;
    endcase
  end

  // Root requests: speed up saturates, speed down clamps at zero.
  always_comb begin
    sqrt_state     = state_q[10] | state_q[14];
    sqrt_req.start = sqrt_state && !run_q;
    if (state_q == ST_SQRT_SU) begin
      sqrt_req.radicand = (up_sum[SQR_W+1:SQR_W] != 2'b00) ? '1 : up_sum[SQR_W-1:0];
    end else if (two_p >= {1'b0, cr2_q}) begin
      sqrt_req.radicand = '0;
    end else begin
      sqrt_req.radicand = cr2_q - two_p[SQR_W-1:0];
    end
  end

  assign pop_o    = (state_q == ST_IDLE) && item_valid_i;
  assign load_out = (state_q == ST_OUT) && (!out_valid_o || out_ready_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = item_i.accel_zero ? ST_OUT : ST_SQ_E;
        end
      end
      ST_SQ_E:     state_d = ST_SQ_C;
      ST_SQ_C:     state_d = ST_SQ_X;
      ST_SQ_X:     state_d = ST_MUL_AL;
      ST_MUL_AL:   state_d = ST_DIV_AD;
      ST_DIV_AD:   if (div_rsp.done) state_d = ST_DIV_DD;
      ST_DIV_DD:   if (div_rsp.done) state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = (ramp_sum > (SQR_W+1)'(it_q.block_length)) ? ST_DIV_MEET : ST_MUL_SU;
      end
      ST_DIV_MEET: if (div_rsp.done) state_d = ST_MUL_SU;
      ST_MUL_SU:   state_d = ST_SQRT_SU;
      ST_SQRT_SU:  if (sqrt_rsp.done) state_d = ST_DIV_TA;
      ST_DIV_TA:   if (div_rsp.done) state_d = ST_MUL_CR;
      ST_MUL_CR:   state_d = ST_MUL_PD;
      ST_MUL_PD:   state_d = ST_SQRT_SD;
      ST_SQRT_SD:  if (sqrt_rsp.done) state_d = ST_DIV_TD;
      ST_DIV_TD:   if (div_rsp.done) state_d = ST_OUT;
      ST_OUT:      if (load_out) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_req.start || sqrt_req.start) begin
        run_q <= 1'b1;
      end else if (div_rsp.done || sqrt_rsp.done) begin
        run_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        it_q   <= item_i;
        acc_q  <= '0;
        dec_q  <= item_i.block_length;
        cr_q   <= item_i.nominal_speed;
        ta_q   <= '0;
        td_q   <= '0;
        meet_q <= 1'b0;
      end
      ST_SQ_E:   e2_q <= prod;
      ST_SQ_C:   c2_q <= prod;
      ST_SQ_X:   x2_q <= prod;
      ST_MUL_AL: al_q <= prod;
      ST_DIV_AD: if (div_rsp.done) ad_q <= div_rsp.quot[SQR_W-1:0];
      ST_DIV_DD: if (div_rsp.done) dd_q <= div_rsp.quot[SQR_W-1:0];
      ST_CHECK: begin
        meet_q <= (ramp_sum > (SQR_W+1)'(it_q.block_length));
        acc_q  <= ad_q[VAL_W-1:0];
        dec_q  <= it_q.block_length - dd_q[VAL_W-1:0];
      end
      ST_DIV_MEET: begin
        if (div_rsp.done) begin
          acc_q <= meet_pt;
          dec_q <= meet_pt;
        end
      end
      ST_MUL_SU: p_q <= prod;
      ST_SQRT_SU: begin
        if (sqrt_rsp.done) begin
          su_q <= sqrt_rsp.root;
          if (meet_q) begin
            cr_q <= sqrt_rsp.root;
          end
        end
      end
      ST_DIV_TA:  if (div_rsp.done) ta_q <= quot_sat;
      ST_MUL_CR:  cr2_q <= prod;
      ST_MUL_PD:  p_q <= prod;
      ST_SQRT_SD: if (sqrt_rsp.done) sd_q <= sqrt_rsp.root;
      ST_DIV_TD:  if (div_rsp.done) td_q <= quot_sat;
      ST_OUT: ;
      default: ;
    endcase
  end

  // Output register.
  assign span = dec_q - acc_q;

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      accel_end_o      <= acc_q;
      decel_start_o    <= dec_q;
      cruise_speed_o   <= cr_q;
      accel_duration_o <= ta_q;
      decel_duration_o <= td_q;
      cruise_only_o    <= ((it_q.block_length - span) < VAL_W'(tolerance_i));
    end
  end

endmodule
